[src/assert_macros.svh]
// Assertion macros for the RTL of the stepper limit controller; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SPLC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPLC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPLC_ASSERT(label, clk, rst_n, prop, msg)
`define SPLC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[src/splc_pkg.sv]
// Types, constants and helper functions of the stepper limit controller.
`timescale 1ns / 1ps
package splc_pkg;

  localparam int TRAVEL_RANGE  = 4000;
  localparam int BACKOFF_STEPS = 10;

  localparam int POS_W    = 13;
  localparam int CNT_W    = 15;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int UNIT_W   = 4;
  localparam int BACK_W   = (BACKOFF_STEPS < 1) ? 1 : $clog2(BACKOFF_STEPS + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UPPER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOWER = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUARTER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EIGHTH  = 2'd3;

  localparam logic [UNIT_W-1:0] UNIT_FULL = 4'd8;

  typedef struct packed {
    logic                load;
    logic                step;
    logic                back_start;
    logic                back_step;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic run_done;
    logic back_done;
    logic lim_lo;
    logic lim_hi;
    logic out_free;
  } sts_t;

  function automatic logic [UNIT_W-1:0] unit_of_mode(input logic [MODE_W-1:0] mode);
    logic [UNIT_W-1:0] unit;
    unique case (mode)
      MODE_FULL:    unit = 4'd8;
      MODE_HALF:    unit = 4'd4;
      MODE_QUARTER: unit = 4'd2;
      MODE_EIGHTH:  unit = 4'd1;
      default:      unit = 4'd8;
    endcase
    return unit;
  endfunction

endpackage

[src/splc_ctrl.sv]
// Controller state machine that sequences moves, homing and result hand-off.
`timescale 1ns / 1ps
module splc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_home_i,
  output logic             in_ready_o,
  input  splc_pkg::sts_t   sts_i,
  output splc_pkg::cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_BACK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic                          home_q, home_d;
  logic [splc_pkg::STATUS_W-1:0] status_q, status_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    home_d   = home_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          home_d     = in_home_i;
          status_d   = splc_pkg::ST_DONE;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.run_done) begin
          status_d = splc_pkg::ST_DONE;
          state_d  = S_DONE;
        end else if (sts_i.lim_lo) begin
          if (home_q) begin
            cmd_o.back_start = 1'b1;
            status_d         = splc_pkg::ST_DONE;
            state_d          = S_BACK;
          end else begin
            status_d = splc_pkg::ST_LOWER;
            state_d  = S_DONE;
          end
        end else if (sts_i.lim_hi) begin
          status_d = home_q ? splc_pkg::ST_DONE : splc_pkg::ST_UPPER;
          state_d  = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_BACK: begin
        if (sts_i.back_done || sts_i.lim_hi) begin
          state_d = S_DONE;
        end else begin
          cmd_o.back_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      home_q   <= 1'b0;
      status_q <= splc_pkg::ST_DONE;
    end else begin
      state_q  <= state_d;
      home_q   <= home_d;
      status_q <= status_d;
    end
  end

endmodule

[src/splc_dp.sv]
// Datapath holding position, step counters, step mode and the result register.
`timescale 1ns / 1ps
module splc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  splc_pkg::cmd_t                    cmd_i,
  output splc_pkg::sts_t                    sts_o,
  input  logic                              in_home_i,
  input  logic                              in_push_i,
  input  logic [splc_pkg::CNT_W-1:0]        in_count_i,
  input  logic                              in_full_i,
  input  logic                              cfg_we_i,
  input  logic [splc_pkg::MODE_W-1:0]       cfg_mode_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [splc_pkg::STATUS_W-1:0]     out_status_o,
  output logic signed [splc_pkg::POS_W-1:0] out_pos_o,
  output logic [splc_pkg::CNT_W-1:0]        out_made_o
);

  logic signed [splc_pkg::POS_W-1:0] pos_q, pos_d, step_amt;
  logic [splc_pkg::CNT_W-1:0]        made_q, target_q;
  logic [splc_pkg::BACK_W-1:0]       back_q;
  logic [splc_pkg::UNIT_W-1:0]       unit_q;
  logic                              dir_dn_q;
  logic [splc_pkg::MODE_W-1:0]       mode_q;
  logic                              out_valid_q;
  logic [splc_pkg::STATUS_W-1:0]     out_status_q;
  logic signed [splc_pkg::POS_W-1:0] out_pos_q;
  logic [splc_pkg::CNT_W-1:0]        out_made_q;
  logic                              preset;

  assign preset   = in_home_i && in_full_i;
  assign step_amt = $signed(splc_pkg::POS_W'(unit_q));
  assign pos_d    = dir_dn_q ? (pos_q - step_amt) : (pos_q + step_amt);

  assign sts_o.run_done  = (made_q == target_q);
  assign sts_o.back_done = (back_q == splc_pkg::BACK_W'(splc_pkg::BACKOFF_STEPS));
  assign sts_o.lim_lo    = dir_dn_q && (pos_q < $signed(splc_pkg::POS_W'(0)));
  assign sts_o.lim_hi    = !dir_dn_q &&
                           (pos_q > $signed(splc_pkg::POS_W'(splc_pkg::TRAVEL_RANGE)));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mode_q      <= splc_pkg::MODE_FULL;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && preset) begin
        pos_q <= $signed(splc_pkg::POS_W'(splc_pkg::TRAVEL_RANGE));
      end else if (cmd_i.step || cmd_i.back_step) begin
        pos_q <= pos_d;
      end
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end else if (cmd_i.load && in_home_i) begin
        mode_q <= splc_pkg::MODE_FULL;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      made_q   <= '0;
      back_q   <= '0;
      target_q <= preset ? splc_pkg::CNT_W'(splc_pkg::TRAVEL_RANGE) : in_count_i;
      dir_dn_q <= in_home_i ? 1'b1 : in_push_i;
      unit_q   <= in_home_i ? splc_pkg::UNIT_FULL : splc_pkg::unit_of_mode(mode_q);
    end else if (cmd_i.back_start) begin
      dir_dn_q <= 1'b0;
    end else if (cmd_i.step) begin
      made_q <= made_q + 1'b1;
    end else if (cmd_i.back_step) begin
      back_q <= back_q + 1'b1;
    end
    if (cmd_i.finish) begin
      out_status_q <= cmd_i.status;
      out_pos_q    <= pos_q;
      out_made_q   <= made_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pos_o    = out_pos_q;
  assign out_made_o   = out_made_q;

endmodule

[src/stepper_position_limit_controller.sv]
// Top level of the stepper controller with soft travel limits.
//
//   Channel  Dir  Signals               Content
//   s_axis   in   tdata[16:0], tuser    push_req, step_count, full_travel; req_type
//   m_axis   out  tdata[29:0]           status, position, steps_made
//   cfg      in   cfg_data_i[1:0]       step_mode
//
// A move of n steps is loaded, stepped up to n times and then handed off as a result; a home
// adds up to BACKOFF_STEPS back-off steps for the pull-back. One step is issued per cycle
// by the controller and added by the position adder, so the step count sets the time per command.
// Reset clears the position and the step mode to zero and empties the output.
// A result held by a stalled m_axis holds the next result, while the next beat is
// already taken and worked on.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stepper_position_limit_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] push_req, [15:1] step_count, [16] full_travel, [23:17] zero
  input  logic [splc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [14:2] position, [29:15] steps_made, [31:30] zero
  output logic [splc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [splc_pkg::MODE_W-1:0]         cfg_data_i
);

  splc_pkg::cmd_t                    cmd;
  splc_pkg::sts_t                    sts;
  logic [splc_pkg::STATUS_W-1:0]     out_status;
  logic signed [splc_pkg::POS_W-1:0] out_pos;
  logic [splc_pkg::CNT_W-1:0]        out_made;

  assign cfg_ready_o = 1'b1;

  splc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_home_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  splc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_home_i    (s_axis_tuser),
    .in_push_i    (s_axis_tdata[0]),
    .in_count_i   (s_axis_tdata[15:1]),
    .in_full_i    (s_axis_tdata[16]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_mode_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_pos_o    (out_pos),
    .out_made_o   (out_made)
  );

  assign m_axis_tdata = {2'b00, out_made, out_pos, out_status};

  `SPLC_ASSERT_NEVER(a_load_excl, clk_i, rst_ni, cmd.load && (cmd.step || cmd.back_step || cmd.finish), "load overlaps another command")
  `SPLC_ASSERT(a_step_not_done, clk_i, rst_ni, cmd.step |-> !sts.run_done, "step issued after the count was reached")
  `SPLC_ASSERT(a_finish_out, clk_i, rst_ni, cmd.finish |=> m_axis_tvalid, "finished result not presented")
  `SPLC_ASSERT(a_pos_bound, clk_i, rst_ni, m_axis_tvalid |-> (out_pos >= -13'sd8) && (out_pos <= $signed(13'(splc_pkg::TRAVEL_RANGE + 8))), "position outside soft limit band")

endmodule
